/* hw/rtl/sha_pkg.sv */
// package: types, constants and functions for the sha-256 stream hash core
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_EMIT
  } sha_state_t;

  typedef logic [31:0] word_t;

  // control from sequencer to round unit
  typedef struct packed {
    logic       load;    // copy hash words into working vars
    logic       round;   // run one round
    logic [5:0] rnd;     // round number
  } rnd_ctrl_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_POS   = 6'd56;

  function automatic word_t init_h(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t r;
    case (i)
      6'd0: r = 32'h428a2f98; 6'd1: r = 32'h71374491; 6'd2: r = 32'hb5c0fbcf;
      6'd3: r = 32'he9b5dba5; 6'd4: r = 32'h3956c25b; 6'd5: r = 32'h59f111f1;
      6'd6: r = 32'h923f82a4; 6'd7: r = 32'hab1c5ed5; 6'd8: r = 32'hd807aa98;
      6'd9: r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/sha_if.sv */
// stream interfaces for input bytes and digest words
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       start_message;
  logic       end_message;
  modport source (output valid, data_byte, byte_present, start_message, end_message,
                  input ready);
  modport sink (input valid, data_byte, byte_present, start_message, end_message,
                output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* hw/rtl/sha_round.sv */
// shared round unit: message schedule window and working variables
module sha_round
  import sha_pkg::*;
(
  input  logic      clk,
  input  rnd_ctrl_t ctrl,
  input  logic      wr_en,     // write a packed word into the window
  input  logic [3:0] wr_idx,
  input  word_t     wr_data,
  input  word_t     h_in [8],
  output word_t     v_out [8]
);

  word_t w_r [16];
  word_t v_r [8];

  logic [3:0] ri;
  word_t w15, w2, wnew, wr, s1, ch, s0, mj, t1, t2;

  // schedule expansion and round function
  always_comb begin
    ri   = ctrl.rnd[3:0];
    w15  = w_r[ri + 4'd1];
    w2   = w_r[ri + 4'd14];
    wnew = w_r[ri]
         + ({w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3))
         + w_r[ri + 4'd9]
         + ({w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10));
    wr   = ctrl.rnd[5:4] == 2'd0 ? w_r[ri] : wnew;
    s1   = {v_r[4][5:0], v_r[4][31:6]} ^ {v_r[4][10:0], v_r[4][31:11]}
         ^ {v_r[4][24:0], v_r[4][31:25]};
    ch   = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    s0   = {v_r[0][1:0], v_r[0][31:2]} ^ {v_r[0][12:0], v_r[0][31:13]}
         ^ {v_r[0][21:0], v_r[0][31:22]};
    mj   = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1   = v_r[7] + s1 + ch + round_k(ctrl.rnd) + wr;
    t2   = s0 + mj;
  end

  // window and working variable registers
  always_ff @(posedge clk) begin
    if (wr_en) begin
      w_r[wr_idx] <= wr_data;
    end else if (ctrl.round) begin
      w_r[ri] <= wr;
    end
    if (ctrl.load) begin
      v_r <= h_in;
    end else if (ctrl.round) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign v_out = v_r;

endmodule

/* hw/rtl/sha256_stream_hash_core.sv */
// top level: sha-256 stream hash core with byte packing and sequencer
//
//  channel | dir | payload                                          | handshake
//  in_     | in  | data_byte, byte_present, start_message, end_msg  | valid/ready
//  out_    | out | digest_word, word_index, last_word               | valid/ready
//
// a byte request is taken when valid and ready are both high; when it fills a block the
// working variables load from the hash words, then the rounds and an update
// follow, and the input is not ready meanwhile. an end request pads one byte per
// cycle while no compression runs, with one or two compressions (a compression first when
// its own byte fills a block), then eight words one per cycle as out_ready allows.
// rst_n is synchronous; it reloads the initial hash and clears counts.
// the input is not ready while a compression, padding or digest is busy.
module sha256_stream_hash_core
  import sha_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);

  sha_state_t  state_r, state_nxt;
  word_t       h_r [8];
  logic [60:0] bcnt_r, bcnt_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [23:0] part_r, part_nxt;     // partial word bytes
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        fin_r, fin_nxt;       // pad byte 0x80 still to go in
  logic        pad_r, pad_nxt;       // message is being padded
  logic        wrap_r, wrap_nxt;     // pad byte landed inside the length field bytes
  logic        done_r, done_nxt;     // this compression holds the length field
  logic        upd;                  // fold working vars into hash
  logic        init;                 // reload initial hash
  logic        byte_go;
  logic [7:0]  byte_val;
  logic [2:0]  pad_i;
  logic [63:0] bits;
  rnd_ctrl_t   ctrl;
  word_t       v [8];
  logic        in_acc;

  sha_round u_round (
    .clk     (clk),
    .ctrl    (ctrl),
    .wr_en   (byte_go && fill_r[1:0] == 2'd3),
    .wr_idx  (fill_r[5:2]),
    .wr_data ({part_r, byte_val}),
    .h_in    (h_r),
    .v_out   (v)
  );

  assign in_acc = in_ch.valid && in_ch.ready;
  assign bits   = {bcnt_r, 3'b000};
  assign pad_i  = 3'(fill_r - LEN_POS);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    bcnt_nxt   = bcnt_r;
    fill_nxt   = fill_r;
    part_nxt   = part_r;
    rnd_nxt    = rnd_r;
    oidx_nxt   = oidx_r;
    fin_nxt    = fin_r;
    pad_nxt    = pad_r;
    wrap_nxt   = wrap_r;
    done_nxt   = done_r;
    upd        = 1'b0;
    init       = 1'b0;
    byte_go    = 1'b0;
    byte_val   = in_ch.data_byte;
    ctrl       = '{load: 1'b0, round: 1'b0, rnd: rnd_r};
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          if (in_ch.start_message) begin
            init = 1'b1;
            bcnt_nxt = '0;
            fill_nxt = '0;
          end
          byte_go = in_ch.byte_present;
          if (in_ch.byte_present) begin
            bcnt_nxt = (in_ch.start_message ? 61'd0 : bcnt_r) + 61'd1;
          end
          fin_nxt = in_ch.end_message;
          pad_nxt = in_ch.end_message;
          wrap_nxt = 1'b0;
          done_nxt = 1'b0;
          if (byte_go && (in_ch.start_message ? 6'd0 : fill_r) == 6'd63) begin
            ctrl.load = 1'b1;
            rnd_nxt = '0;
            state_nxt = ST_ROUND;
          end else if (in_ch.end_message) begin
            state_nxt = ST_PAD;
          end
          if (in_ch.start_message) begin
            byte_go = 1'b0;
            if (in_ch.byte_present) begin
              fill_nxt = 6'd1;
              part_nxt = {16'd0, in_ch.data_byte};
            end
          end
        end
      end
      ST_PAD: begin
        byte_go = 1'b1;
        fin_nxt = 1'b0;
        // 0x80 first, length only in a block whose pad byte came before it
        if (fin_r) begin
          byte_val = PAD_BYTE;
          if (fill_r >= LEN_POS) wrap_nxt = 1'b1;
        end else if (fill_r >= LEN_POS && !wrap_r) begin
          byte_val = bits[8*(7-pad_i) +: 8];
        end else begin
          byte_val = 8'd0;
        end
        if (fill_r == 6'd63) begin
          ctrl.load = 1'b1;
          rnd_nxt = '0;
          state_nxt = ST_ROUND;
          wrap_nxt = 1'b0;
          done_nxt = !fin_r && !wrap_r;
        end
      end
      ST_ROUND: begin
        ctrl.round = 1'b1;
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        upd = 1'b1;
        if (done_r) begin
          state_nxt = ST_EMIT;
        end else if (pad_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (out_ch.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            init = 1'b1;
            bcnt_nxt = '0;
            fill_nxt = '0;
            pad_nxt = 1'b0;
            done_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (byte_go) begin
      fill_nxt = fill_r + 6'd1;
      part_nxt = {part_r[15:0], byte_val};
    end
  end

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      bcnt_r  <= '0;
      fill_r  <= '0;
      rnd_r   <= '0;
      oidx_r  <= '0;
      fin_r   <= 1'b0;
      pad_r   <= 1'b0;
      wrap_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bcnt_r  <= bcnt_nxt;
      fill_r  <= fill_nxt;
      rnd_r   <= rnd_nxt;
      oidx_r  <= oidx_nxt;
      fin_r   <= fin_nxt;
      pad_r   <= pad_nxt;
      wrap_r  <= wrap_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    part_r <= part_nxt[23:0];
  end

  // hash words
  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else if (upd) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v[i];
    end
  end

  assign out_ch.valid       = state_r == ST_EMIT;
  assign out_ch.digest_word = h_r[oidx_r];
  assign out_ch.word_index  = oidx_r;
  assign out_ch.last_word   = oidx_r == 3'd7;

endmodule

/* hw/rtl/sha_checker.sv */
// port checker for the sha-256 stream hash core
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // no new request while a digest is shown
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready during digest");

  // last flag marks word seven
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last flag mismatch");

  // word index steps by one after each taken word
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_word |=>
      out_valid && out_word_index == $past(out_word_index) + 3'd1)
    else $error("word index skipped");

  // digest starts at word zero
  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> out_word_index == 3'd0) else $error("digest not at word zero");

endmodule

bind sha256_stream_hash_core sha_checker u_sha_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_word_index (out_ch.word_index),
  .out_last_word  (out_ch.last_word)
);

/* test/sha256_stream_hash_core_tb_if.sv */
// testbench copy note: interfaces come from the rtl; this file holds the byte request and digest result types
`timescale 1ns / 100ps
package sha_tb_pkg;
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       start_message;
    logic       end_message;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_res_t;
endpackage

/* test/sha256_stream_hash_core_tb.sv */
// testbench for the sha-256 stream hash core: random byte streams checked against a digest model
`timescale 1ns / 100ps
module sha256_stream_hash_core_tb;
  import sha_pkg::*;
  import sha_tb_pkg::*;

  // digest model and store of pending digest words
  class digest_board;
    logic [31:0] hw [8];
    logic [31:0] blk [16];
    logic [60:0] nbytes;
    int unsigned fill;
    digest_res_t pending [$];
    int unsigned mismatches;
    int unsigned words_seen;
    int unsigned messages;

    function void restart();
      for (int i = 0; i < 8; i++) hw[i] = init_value(i);
      nbytes = '0;
      fill = 0;
    endfunction

    function logic [31:0] init_value(int i);
      logic [31:0] iv [8];
      iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
             32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
      return iv[i];
    endfunction

    function logic [31:0] rot(logic [31:0] x, int k);
      return (x >> k) | (x << (32 - k));
    endfunction

    function logic [31:0] kconst(int r);
      logic [31:0] kt [64];
      kt = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
      return kt[r];
    endfunction

    function void compress_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wr, t1, t2, a15, a2;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 0; i < 8; i++) v[i] = hw[i];
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          wr = w[r];
        end else begin
          a15 = w[(r - 15) & 15];
          a2 = w[(r - 2) & 15];
          wr = w[r & 15] + (rot(a15, 7) ^ rot(a15, 18) ^ (a15 >> 3)) + w[(r - 7) & 15]
             + (rot(a2, 17) ^ rot(a2, 19) ^ (a2 >> 10));
          w[r & 15] = wr;
        end
        t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(r) + wr;
        t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hw[i] = hw[i] + v[i];
    endfunction

    function void absorb(logic [7:0] b);
      blk[fill >> 2] = ((fill & 3) == 0) ? {24'h0, b} : {blk[fill >> 2][23:0], b};
      fill++;
      if (fill == 64) begin
        compress_block();
        fill = 0;
      end
    endfunction

    // note one accepted byte request
    function void note_request(byte_req_t rq);
      logic [63:0] bits;
      digest_res_t d;
      if (rq.start_message) restart();
      if (rq.byte_present) begin
        absorb(rq.data_byte);
        nbytes = nbytes + 61'd1;
      end
      if (!rq.end_message) return;
      bits = {nbytes, 3'b000};
      absorb(PAD_BYTE);
      while (fill != LEN_POS) absorb(8'h00);
      for (int i = 0; i < 8; i++) absorb(bits[63 - 8 * i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.digest_word = hw[i];
        d.word_index = i[2:0];
        d.last_word = (i == 7);
        pending.push_back(d);
      end
      messages++;
      restart();
    endfunction

    // compare one digest word with the oldest pending one
    function void check_word(digest_res_t got);
      digest_res_t want;
      words_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest word %h idx %0d", got.digest_word,
                                       got.word_index);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: want %h/%0d/%0b got %h/%0d/%0b", want.digest_word,
                   want.word_index, want.last_word, got.digest_word, got.word_index,
                   got.last_word);
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  sha_in_if in_ch ();
  sha_out_if out_ch ();
  digest_board board;
  bit sink_quiet = 0;
  bit sink_hold = 0;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  int unsigned stall_hits = 0;

  sha256_stream_hash_core dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.start_message = 1'b0;
    in_ch.end_message = 1'b0;
    out_ch.ready = 1'b0;
    board = new();
    board.restart();
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        board.note_request({in_ch.data_byte, in_ch.byte_present, in_ch.start_message,
                            in_ch.end_message});
        sent++;
      end
      if (out_ch.valid && out_ch.ready)
        board.check_word({out_ch.digest_word, out_ch.word_index, out_ch.last_word});
      if (in_ch.valid && !in_ch.ready && sink_hold) stall_hits++;
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request moved for %0d cycles", idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // receiver: random stalls, a quiet stretch and one long hold-off
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (sink_hold) out_ch.ready <= 1'b0;
      else if (sink_quiet) out_ch.ready <= 1'b1;
      else out_ch.ready <= ($urandom_range(99) >= 13);
    end
  end

  // one request, held until accepted; gaps drawn at random
  task automatic send_req(byte_req_t rq, bit no_gaps);
    while (!no_gaps && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    {in_ch.data_byte, in_ch.byte_present, in_ch.start_message, in_ch.end_message} <= rq;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_message(int len, bit with_start, bit last_has_byte, bit no_gaps);
    byte_req_t rq;
    for (int i = 0; i < len; i++) begin
      rq.data_byte = 8'($urandom_range(255));
      rq.byte_present = 1'b1;
      rq.start_message = with_start && (i == 0);
      rq.end_message = (i == len - 1) && last_has_byte;
      send_req(rq, no_gaps);
      // noise: absent bytes with random data in between
      if ($urandom_range(99) < 5 && !rq.end_message) begin
        rq = {8'($urandom_range(255)), 1'b0, 1'b0, 1'b0};
        send_req(rq, no_gaps);
      end
    end
    if (!last_has_byte || len == 0) begin
      rq = {8'($urandom_range(255)), 1'b0, 1'(with_start && len == 0), 1'b1};
      send_req(rq, no_gaps);
    end
  endtask

  // stimulus
  initial begin
    int len;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: empty message, bytes without start, extremes of the data
    send_req({8'hff, 1'b0, 1'b1, 1'b1}, 0);
    send_req({8'h00, 1'b1, 1'b0, 1'b0}, 0);
    send_req({8'hff, 1'b1, 1'b0, 1'b1}, 0);
    send_req({8'h5a, 1'b0, 1'b0, 1'b1}, 0);
    send_req({8'h61, 1'b1, 1'b1, 1'b0}, 0);
    send_req({8'h62, 1'b1, 1'b0, 1'b0}, 0);
    send_req({8'h63, 1'b1, 1'b0, 1'b1}, 0);
    send_req({8'h11, 1'b1, 1'b0, 1'b0}, 0);
    send_req({8'h22, 1'b1, 1'b1, 1'b1}, 0);
    // padding boundaries: 55 and 56 byte messages
    send_message(55, 1, 1, 0);
    send_message(56, 1, 1, 0);
    // long receiver hold-off while the sender keeps offering
    sink_hold = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        sink_hold = 0;
      end
      begin
        send_message(3, 1, 1, 1);
        send_message(2, 1, 1, 1);
        send_message(1, 1, 1, 1);
      end
    join
    // random messages, one quiet stretch with no idling
    while (sent < 470) begin
      sink_quiet = (sent > 250 && sent < 330);
      case ($urandom_range(9))
        0: len = 0;
        1: len = 64 + $urandom_range(70);
        default: len = $urandom_range(20);
      endcase
      if (len > int'(470 - sent)) len = int'(470 - sent);
      send_message(len, $urandom_range(3) != 0, 1'($urandom_range(1)), sink_quiet);
    end
    sink_quiet = 0;
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d byte requests over %0d messages, %0d digest words checked",
             sent, board.messages, board.words_seen);
    $display("input stalled %0d cycles under receiver hold-off", stall_hits);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("FAIL");
    end
    $finish;
  end
endmodule
